[rtl/asod_pkg.sv]
// package for the accelerometer shake and orientation detector
// holds the shared widths, face and register codes and the inter-stage beat types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package asod_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;
    localparam int SQ_W     = 39;
    localparam int MAG_W    = SQ_W + 1;
    localparam int THR_W    = 39;
    localparam int CFG_IDX_W = 2;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(130000000);

    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_EN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FACE_EN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(2);

    typedef logic [2:0] face_t;
    localparam face_t FACE_NONE = 3'd6;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // window sums handed from the accumulator to the square stage
    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } win_t;

    // squared sums plus the positive flag of each sum
    typedef struct packed {
        logic [SQ_W-1:0] qx;
        logic [SQ_W-1:0] qy;
        logic [SQ_W-1:0] qz;
        logic            px;
        logic            py;
        logic            pz;
    } sq_t;

endpackage

`default_nettype wire

[rtl/accel_shake_and_orientation_detect_core.sv]
// top level of the accelerometer shake and orientation detector
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// sample    | in_valid/in_ready, accel_x/y/z, read_error| in
// result    | out_valid/out_ready, shake, face,         | out
//           | face_changed, magnitude_sq                |
// config    | cfg_we, cfg_index, cfg_wdata              | in
// one sample beat per cycle while in_ready is high, set by the single add per axis
// in the accumulator; out_valid is registered behind the square register
// path: accumulator register, square register, decision/result register
// rst_n clears sums, count and face (to none); enables off, threshold to 130000000
// a full pipe stalls sample beats only at the last beat of a window
// depends on asod_pkg, asod_accum, asod_square, asod_decide
`timescale 1ns / 1ps
`default_nettype none

module accel_shake_and_orientation_detect_core
    import asod_pkg::*;
#(
    parameter int WINDOW_LEN  = 10,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  accel_x,
    input  wire logic signed [SAMPLE_W-1:0]  accel_y,
    input  wire logic signed [SAMPLE_W-1:0]  accel_z,
    input  wire logic                        read_error,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             shake,
    output logic [2:0]                       face,
    output logic                             face_changed,
    output logic [SQ_W-1:0]                  magnitude_sq,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [THR_W-1:0]            cfg_wdata
);

    logic             shake_en_reg;
    logic             face_en_reg;
    logic [THR_W-1:0] threshold_reg;

    logic win_valid;
    logic win_ready;
    win_t win;
    logic sq_valid;
    logic sq_ready;
    sq_t  sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shake_en_reg  <= 1'b0;
            face_en_reg   <= 1'b0;
            threshold_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHAKE_EN:  shake_en_reg  <= cfg_wdata[0];
                REG_FACE_EN:   face_en_reg   <= cfg_wdata[0];
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    asod_accum #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .read_error (read_error),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win        (win)
    );

    asod_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win),
        .sq_valid  (sq_valid),
        .sq_ready  (sq_ready),
        .sq        (sq)
    );

    asod_decide u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .shake_enable    (shake_en_reg),
        .face_enable     (face_en_reg),
        .shake_threshold (threshold_reg),
        .sq_valid        (sq_valid),
        .sq_ready        (sq_ready),
        .sq              (sq),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .shake           (shake),
        .face            (face),
        .face_changed    (face_changed),
        .magnitude_sq    (magnitude_sq)
    );

endmodule

`default_nettype wire

[rtl/asod_accum.sv]
// window accumulator: sums good samples and counts every beat
// hands the finished window sums on in a registered beat; uses asod_pkg
`timescale 1ns / 1ps
`default_nettype none

module asod_accum
    import asod_pkg::*;
#(
    parameter int WINDOW_LEN  = 10,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] accel_x,
    input  wire logic signed [SAMPLE_W-1:0] accel_y,
    input  wire logic signed [SAMPLE_W-1:0] accel_z,
    input  wire logic                       read_error,
    output logic                            win_valid,
    input  wire logic                       win_ready,
    output win_t                            win
);

    localparam int CNT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic signed [SUM_W-1:0] sum_z_reg;
    logic                    win_valid_reg;
    win_t                    win_reg;

    logic                    last;
    logic                    fire;
    logic signed [SUM_W-1:0] add_x;
    logic signed [SUM_W-1:0] add_y;
    logic signed [SUM_W-1:0] add_z;
    win_t                    sums_next;

    always_comb
    begin
        last     = (count_reg == CNT_LAST);
        in_ready = !last || !win_valid_reg || win_ready;
        fire     = in_valid && in_ready;
        // only the low sample bits count, sign extended
        add_x = read_error ? '0 : SUM_W'($signed(accel_x[SAMPLE_BITS-1:0]));
        add_y = read_error ? '0 : SUM_W'($signed(accel_y[SAMPLE_BITS-1:0]));
        add_z = read_error ? '0 : SUM_W'($signed(accel_z[SAMPLE_BITS-1:0]));
        sums_next.x = sum_x_reg + add_x;
        sums_next.y = sum_y_reg + add_y;
        sums_next.z = sum_z_reg + add_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            if (win_ready)
            begin
                win_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                if (last)
                begin
                    count_reg     <= '0;
                    sum_x_reg     <= '0;
                    sum_y_reg     <= '0;
                    sum_z_reg     <= '0;
                    win_valid_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    sum_x_reg <= sums_next.x;
                    sum_y_reg <= sums_next.y;
                    sum_z_reg <= sums_next.z;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
        begin
            win_reg <= sums_next;
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LAST)
        else $error("window count past window end");

    a_error_no_add: assert property (@(posedge clk) disable iff (!rst_n)
        fire && read_error && !last |=> sum_x_reg == $past(sum_x_reg)
            && sum_y_reg == $past(sum_y_reg) && sum_z_reg == $past(sum_z_reg))
        else $error("failed read changed the window sums");

    a_window_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> win_valid_reg && count_reg == '0)
        else $error("window end did not produce a beat");

endmodule

`default_nettype wire

[rtl/asod_square.sv]
// square stage: squares each window sum and notes which sums are positive
// registered beat out; uses asod_pkg
`timescale 1ns / 1ps
`default_nettype none

module asod_square
    import asod_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic win_valid,
    output logic      win_ready,
    input  wire win_t win,
    output logic      sq_valid,
    input  wire logic sq_ready,
    output sq_t       sq
);

    logic       sq_valid_reg;
    sq_t        sq_reg;
    sq_t        sq_next;
    logic       fire;
    logic [SUM_W-1:0]   abs_x;
    logic [SUM_W-1:0]   abs_y;
    logic [SUM_W-1:0]   abs_z;
    logic [2*SUM_W-1:0] prod_x;
    logic [2*SUM_W-1:0] prod_y;
    logic [2*SUM_W-1:0] prod_z;

    always_comb
    begin
        win_ready = !sq_valid_reg || sq_ready;
        fire      = win_valid && win_ready;
        abs_x  = win.x[SUM_W-1] ? SUM_W'(-win.x) : SUM_W'(win.x);
        abs_y  = win.y[SUM_W-1] ? SUM_W'(-win.y) : SUM_W'(win.y);
        abs_z  = win.z[SUM_W-1] ? SUM_W'(-win.z) : SUM_W'(win.z);
        prod_x = abs_x * abs_x;
        prod_y = abs_y * abs_y;
        prod_z = abs_z * abs_z;
        sq_next.qx = prod_x[SQ_W-1:0];
        sq_next.qy = prod_y[SQ_W-1:0];
        sq_next.qz = prod_z[SQ_W-1:0];
        sq_next.px = !win.x[SUM_W-1] && (win.x != '0);
        sq_next.py = !win.y[SUM_W-1] && (win.y != '0);
        sq_next.pz = !win.z[SUM_W-1] && (win.z != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (win_ready)
        begin
            sq_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq_valid = sq_valid_reg;
    assign sq       = sq_reg;

endmodule

`default_nettype wire

[rtl/asod_decide.sv]
// decision stage: magnitude sum, shake compare and face pick
// holds the current face and the result register; uses asod_pkg
`timescale 1ns / 1ps
`default_nettype none

module asod_decide
    import asod_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shake_enable,
    input  wire logic             face_enable,
    input  wire logic [THR_W-1:0] shake_threshold,
    input  wire logic             sq_valid,
    output logic                  sq_ready,
    input  wire sq_t              sq,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  shake,
    output face_t                 face,
    output logic                  face_changed,
    output logic [SQ_W-1:0]       magnitude_sq
);

    logic            out_valid_reg;
    face_t           orient_reg;
    face_t           orient_next;
    logic            shake_reg;
    logic            shake_next;
    logic            changed_reg;
    logic            changed_next;
    logic [SQ_W-1:0] mag_reg;
    logic [SQ_W-1:0] mag_next;
    logic            fire;
    logic [MAG_W-1:0] mag;
    axis_t           axis;
    logic [SQ_W-1:0] best_sq;
    logic            best_pos;
    face_t           picked;

    always_comb
    begin
        sq_ready = !out_valid_reg || out_ready;
        fire     = sq_valid && sq_ready;
        mag = MAG_W'(sq.qx) + MAG_W'(sq.qy) + MAG_W'(sq.qz);
        mag_next   = mag[MAG_W-1] ? '1 : mag[SQ_W-1:0];
        shake_next = shake_enable && (mag > MAG_W'(shake_threshold));

        // ties keep the earlier axis
        axis     = AXIS_X;
        best_sq  = sq.qx;
        best_pos = sq.px;
        if (sq.qy > best_sq)
        begin
            axis     = AXIS_Y;
            best_sq  = sq.qy;
            best_pos = sq.py;
        end
        if (sq.qz > best_sq)
        begin
            axis     = AXIS_Z;
            best_pos = sq.pz;
        end
        picked = {axis, best_pos};

        orient_next  = orient_reg;
        changed_next = 1'b0;
        if (face_enable)
        begin
            orient_next  = picked;
            changed_next = (picked != orient_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            orient_reg    <= FACE_NONE;
        end
        else
        begin
            if (sq_ready)
            begin
                out_valid_reg <= sq_valid;
            end
            if (fire)
            begin
                orient_reg <= orient_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            shake_reg   <= shake_next;
            changed_reg <= changed_next;
            mag_reg     <= mag_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign shake        = shake_reg;
    assign face         = orient_reg;
    assign face_changed = changed_reg;
    assign magnitude_sq = mag_reg;

    a_changed_has_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && changed_reg |-> orient_reg != FACE_NONE)
        else $error("face change reported without a face");

    a_shake_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && shake_reg |-> mag_reg != '0)
        else $error("shake reported with zero magnitude");

    a_face_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> orient_reg == $past(orient_reg))
        else $error("face changed without a beat");

endmodule

`default_nettype wire

[verif/tb_accel_shake_and_orientation_detect_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for accel_shake_and_orientation_detect_core
// drives sample beats through a queue and checks window results against a window predictor
// depends on asod_pkg and accel_shake_and_orientation_detect_core

module tb_accel_shake_and_orientation_detect_core;
    import asod_pkg::*;

    localparam int WIN         = 10;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 250;
    localparam int IDLE_PCT    = 26;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BEATS = 75;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam longint MAG_SAT = (longint'(1) << SQ_W) - 1;

    typedef enum int {STY_FULL, STY_QUIET, STY_LEAN} style_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic                       err;
    } sample_t;

    typedef struct packed {
        logic            shake;
        face_t           face;
        logic            changed;
        logic [SQ_W-1:0] mag;
    } window_result_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] accel_x    = '0;
    logic signed [SAMPLE_W-1:0] accel_y    = '0;
    logic signed [SAMPLE_W-1:0] accel_z    = '0;
    logic                       read_error = 1'b0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic                       shake;
    logic [2:0]                 face;
    logic                       face_changed;
    logic [SQ_W-1:0]            magnitude_sq;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [THR_W-1:0]           cfg_wdata  = '0;

    // window predictor state and its copy of the settings
    logic signed [SUM_W-1:0] acc_x       = '0;
    logic signed [SUM_W-1:0] acc_y       = '0;
    logic signed [SUM_W-1:0] acc_z       = '0;
    int                      reads_taken = 0;
    face_t                   face_held   = FACE_NONE;
    logic                    shake_en_m  = 1'b0;
    logic                    face_en_m   = 1'b0;
    longint                  thresh_m    = longint'(THR_RESET);

    sample_t        sample_q[$];
    window_result_t window_results_q[$];
    sample_t        next_beat;
    window_result_t want;
    int             queued_total   = 0;
    int             accepted_total = 0;
    int             fail_count     = 0;
    int unsigned    cycle_count    = 0;
    int             hold_left      = 0;
    bit             hold_done      = 1'b0;
    bit             hold_armed     = 1'b0;
    bit             no_gaps        = 1'b0;
    face_t          lean           = '0;

    accel_shake_and_orientation_detect_core #(
        .WINDOW_LEN  (WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .read_error   (read_error),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .shake        (shake),
        .face         (face),
        .face_changed (face_changed),
        .magnitude_sq (magnitude_sq),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic absorb_sample(input sample_t s);
        longint         sx, sy, sz, qx, qy, qz, total, best, best_sq;
        axis_t          axis;
        face_t          face_next;
        window_result_t r;
        if (!s.err)
        begin
            acc_x = acc_x + s.x;
            acc_y = acc_y + s.y;
            acc_z = acc_z + s.z;
        end
        reads_taken++;
        if (reads_taken < WIN)
            return;
        sx = acc_x;
        sy = acc_y;
        sz = acc_z;
        qx = sx * sx;
        qy = sy * sy;
        qz = sz * sz;
        total = qx + qy + qz;
        r.shake = shake_en_m && (total > thresh_m);
        r.changed = 1'b0;
        if (face_en_m)
        begin
            // ties keep the earlier axis, a zero sum gives the negative face
            axis = AXIS_X;
            best = sx;
            best_sq = qx;
            if (qy > best_sq)
            begin
                axis = AXIS_Y;
                best = sy;
                best_sq = qy;
            end
            if (qz > best_sq)
            begin
                axis = AXIS_Z;
                best = sz;
            end
            face_next = face_t'(2 * int'(axis) + ((best > 0) ? 1 : 0));
            r.changed = (face_next != face_held);
            face_held = face_next;
        end
        r.face = face_held;
        r.mag = (total > MAG_SAT) ? SQ_W'(MAG_SAT) : SQ_W'(total);
        window_results_q.push_back(r);
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        reads_taken = 0;
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_sample(sample_t'({accel_x, accel_y, accel_z, read_error}));
                accepted_total++;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_beat = sample_q.pop_front();
                    in_valid   <= 1'b1;
                    accel_x    <= next_beat.x;
                    accel_y    <= next_beat.y;
                    accel_z    <= next_beat.z;
                    read_error <= next_beat.err;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (window_results_q.size() == 0)
                begin
                    $error("result beat with no window pending");
                    fail_count++;
                end
                else
                begin
                    want = window_results_q.pop_front();
                    if (shake !== want.shake)
                    begin
                        $error("shake expected %0d got %0d", want.shake, shake);
                        fail_count++;
                    end
                    if (face !== want.face)
                    begin
                        $error("face expected %0d got %0d", want.face, face);
                        fail_count++;
                    end
                    if (face_changed !== want.changed)
                    begin
                        $error("face_changed expected %0d got %0d", want.changed, face_changed);
                        fail_count++;
                    end
                    if (magnitude_sq !== want.mag)
                    begin
                        $error("magnitude_sq expected %0d got %0d", want.mag, magnitude_sq);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic sample_t make_sample(style_t sty);
        sample_t s;
        int      peak;
        s.err = ($urandom_range(99) < 12);
        s.x = SAMPLE_W'(int'($urandom_range(400)) - 200);
        s.y = SAMPLE_W'(int'($urandom_range(400)) - 200);
        s.z = SAMPLE_W'(int'($urandom_range(400)) - 200);
        case (sty)
            STY_FULL:
            begin
                s.x = SAMPLE_W'($urandom());
                s.y = SAMPLE_W'($urandom());
                s.z = SAMPLE_W'($urandom());
            end
            STY_LEAN:
            begin
                // the dominant face drifts now and then so face changes stay rare
                if ($urandom_range(39) == 0)
                    lean = face_t'($urandom_range(5));
                peak = $urandom_range(32767, 8000);
                if (!lean[0])
                    peak = -peak;
                case (lean[2:1])
                    2'd0:    s.x = SAMPLE_W'(peak);
                    2'd1:    s.y = SAMPLE_W'(peak);
                    default: s.z = SAMPLE_W'(peak);
                endcase
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic style_t pick_style();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return STY_FULL;
        if (roll < 55)
            return STY_QUIET;
        return STY_LEAN;
    endfunction

    function automatic logic [THR_W-1:0] rand_threshold();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return THR_W'(r >> $urandom_range(25));
    endfunction

    function automatic logic [THR_W-1:0] enable_word(bit en);
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return {r[THR_W-1:1], en};
    endfunction

    task automatic queue_sample(input sample_t s);
        sample_q.push_back(s);
        queued_total++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SHAKE_EN:  shake_en_m = data[0];
            REG_FACE_EN:   face_en_m = data[0];
            REG_THRESHOLD: thresh_m = longint'({25'd0, data});
            default: ;
        endcase
    endtask

    task automatic configure(input logic [THR_W-1:0] se, input logic [THR_W-1:0] fe,
                             input logic [THR_W-1:0] thr, input bit spare);
        write_reg(REG_SHAKE_EN, se);
        write_reg(REG_FACE_EN, fe);
        write_reg(REG_THRESHOLD, thr);
        if (spare)
            write_reg(REG_SPARE, rand_threshold());
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (accepted_total != queued_total || window_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        sample_t s;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one window on reset settings: face tracking off, face stays none
        repeat (WIN) queue_sample(make_sample(STY_LEAN));
        wait_idle();

        configure(enable_word(1'b1), enable_word(1'b1), '0, 1'b0);
        // x and y tie in magnitude, x wins; failed reads carry the extreme codes
        repeat (5) queue_sample(sample_t'({16'sh7fff, -16'sh7fff, 16'sh0000, 1'b0}));
        repeat (5) queue_sample(sample_t'({16'sh8000, 16'sh8000, 16'sh8000, 1'b1}));
        // all reads failed: zero sums, negative x face, magnitude equal to threshold
        repeat (WIN)
        begin
            s = make_sample(STY_FULL);
            s.err = 1'b1;
            queue_sample(s);
        end
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: configure(enable_word(1'b1), enable_word(1'b1), THR_RESET, 1'b1);
                1: configure(enable_word(1'b0), enable_word(1'b1), rand_threshold(), 1'b0);
                2: configure(enable_word(1'b1), enable_word(1'b0), '1, 1'b1);
                3: configure(enable_word(1'b1), enable_word(1'b1), '0, 1'b0);
                4: configure(enable_word(1'b0), enable_word(1'b0), rand_threshold(), 1'b0);
                default: configure(enable_word($urandom_range(1)), enable_word($urandom_range(1)),
                                   rand_threshold(), $urandom_range(1));
            endcase
            if (p == 0)
                hold_armed = 1'b1;
            if (p == 3)
                no_gaps = 1'b1;
            repeat (PHASE_BEATS) queue_sample(make_sample(pick_style()));
            wait_idle();
            no_gaps = 1'b0;
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
